FILE: rtl/jkse_pkg.sv
// ----------------------------------------------------------------------------
// jkse_pkg
// Shared types and constants for the JSON key string extractor.
// ----------------------------------------------------------------------------
package jkse_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_KEY_CHARS_LOW  = 2'd0;
    localparam logic [1:0] CFG_KEY_CHARS_HIGH = 2'd1;
    localparam logic [1:0] CFG_KEY_LENGTH     = 2'd2;
    localparam logic [1:0] CFG_VALUE_CAPACITY = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    // Character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // One result item
    typedef struct packed {
        logic [7:0] value_length;
        logic       found;
        logic       done_res;
        logic       has_byte;
        logic [7:0] value_byte;
    } jkse_result_t;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_LF) || (b == CH_CR) || (b == CH_TAB);
    endfunction

endpackage

FILE: rtl/jkse_cfg_regs.sv
// ----------------------------------------------------------------------------
// jkse_cfg_regs
// Configuration registers: key bytes, clamped key length, clamped capacity.
// ----------------------------------------------------------------------------
module jkse_cfg_regs
    import jkse_pkg::*;
#(
    parameter int MAX_KEY_CHARS      = 16,
    parameter int MAX_VALUE_CAPACITY = 256,
    localparam int KLEN_W = $clog2(MAX_KEY_CHARS + 1),
    localparam int CAP_W  = $clog2(MAX_VALUE_CAPACITY + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output logic [7:0]             key_bytes [MAX_KEY_CHARS],
    output logic [KLEN_W-1:0]      key_len,
    output logic [CAP_W-1:0]       capacity
);

    logic [7:0]        key_bytes_reg [MAX_KEY_CHARS];
    logic [KLEN_W-1:0] key_len_reg;
    logic [CAP_W-1:0]  capacity_reg;
    logic [4:0]        wr_len;
    logic [8:0]        wr_cap;

    assign wr_len = cfg_wdata[4:0];
    assign wr_cap = cfg_wdata[8:0];

    // Key bytes: only the characters that can ever be compared are kept
    for (genvar i = 0; i < MAX_KEY_CHARS; i++) begin : g_key
        localparam logic [1:0] WORD = (i < 8) ? CFG_KEY_CHARS_LOW : CFG_KEY_CHARS_HIGH;
        localparam int         LSB  = 8 * (i % 8);
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                key_bytes_reg[i] <= 8'd0;
            end else if (cfg_wr_en && cfg_index == WORD) begin
                key_bytes_reg[i] <= cfg_wdata[LSB +: 8];
            end
        end
        assign key_bytes[i] = key_bytes_reg[i];
    end

    // Length and capacity, clamped to the build limits as they are written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_len_reg  <= '0;
            capacity_reg <= CAP_W'(MAX_VALUE_CAPACITY);
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_KEY_LENGTH) begin
                key_len_reg <= (wr_len > 5'(MAX_KEY_CHARS)) ?
                               KLEN_W'(MAX_KEY_CHARS) : KLEN_W'(wr_len);
            end
            if (cfg_index == CFG_VALUE_CAPACITY) begin
                capacity_reg <= (wr_cap > 9'(MAX_VALUE_CAPACITY)) ?
                                CAP_W'(MAX_VALUE_CAPACITY) : CAP_W'(wr_cap);
            end
        end
    end

    assign key_len  = key_len_reg;
    assign capacity = capacity_reg;

endmodule

FILE: rtl/jkse_scan.sv
// ----------------------------------------------------------------------------
// jkse_scan
// Per-byte scan state machine: key match, colon, opening quote, value copy.
// ----------------------------------------------------------------------------
module jkse_scan
    import jkse_pkg::*;
#(
    parameter int MAX_KEY_CHARS      = 16,
    parameter int MAX_VALUE_CAPACITY = 256,
    localparam int KLEN_W = $clog2(MAX_KEY_CHARS + 1),
    localparam int CAP_W  = $clog2(MAX_VALUE_CAPACITY + 1),
    localparam int KIDX_W = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic [7:0]        text_byte,
    input  logic              is_last,
    input  logic [7:0]        key_bytes [MAX_KEY_CHARS],
    input  logic [KLEN_W-1:0] key_len,
    input  logic [CAP_W-1:0]  capacity,
    output logic              res_valid,
    output jkse_result_t      res
);

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_KEY   = 3'd1,
        MODE_COLON = 3'd2,
        MODE_OPEN  = 3'd3,
        MODE_VALUE = 3'd4
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [4:0] pos_reg, pos_next;
    logic [7:0] count_reg, count_next;
    logic       finished_reg, finished_next;

    logic [8:0] cap9;
    logic [7:0] key_ch;
    logic       done, found, has;

    assign cap9 = 9'(capacity);

    // Select the key character at the current match position
    always_comb begin
        key_ch = 8'd0;
        if (pos_reg < 5'(MAX_KEY_CHARS)) begin
            key_ch = key_bytes[pos_reg[KIDX_W-1:0]];
        end
    end

    // Step the scan for one accepted item
    always_comb begin
        mode_next     = mode_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        finished_next = finished_reg;
        done          = 1'b0;
        found         = 1'b0;
        has           = 1'b0;
        res_valid     = 1'b0;
        res           = '0;

        if (in_accept) begin
            if (finished_reg) begin
                // Ignore bytes until the end of the buffer rearms
                if (is_last) begin
                    mode_next     = MODE_IDLE;
                    pos_next      = 5'd0;
                    count_next    = 8'd0;
                    finished_next = 1'b0;
                end
            end else begin
                if (cap9 == 9'd0) begin
                    done = 1'b1;
                end else begin
                    case (mode_reg)
                        MODE_IDLE: begin
                            if (text_byte == CH_QUOTE) begin
                                mode_next = MODE_KEY;
                                pos_next  = 5'd0;
                            end
                        end
                        MODE_KEY: begin
                            if (pos_reg < 5'(key_len)) begin
                                if (text_byte == key_ch) begin
                                    pos_next = pos_reg + 5'd1;
                                end else if (text_byte == CH_QUOTE) begin
                                    pos_next = 5'd0;
                                end else begin
                                    mode_next = MODE_IDLE;
                                end
                            end else begin
                                mode_next = (text_byte == CH_QUOTE) ? MODE_COLON : MODE_IDLE;
                            end
                        end
                        MODE_COLON: begin
                            if (text_byte == CH_COLON) begin
                                mode_next = MODE_OPEN;
                            end else if (!is_blank(text_byte)) begin
                                mode_next = MODE_IDLE;
                            end
                        end
                        MODE_OPEN: begin
                            if (text_byte == CH_QUOTE) begin
                                count_next = 8'd0;
                                if (cap9 <= 9'd1) begin
                                    done = 1'b1;
                                end else begin
                                    mode_next = MODE_VALUE;
                                end
                            end else if (!is_blank(text_byte)) begin
                                done = 1'b1;
                            end
                        end
                        MODE_VALUE: begin
                            if (text_byte == CH_QUOTE || {1'b0, count_reg} + 9'd1 >= cap9) begin
                                done  = 1'b1;
                                found = (count_reg != 8'd0);
                            end else begin
                                has        = 1'b1;
                                count_next = count_reg + 8'd1;
                                if (is_last || {1'b0, count_next} + 9'd1 >= cap9) begin
                                    done  = 1'b1;
                                    found = 1'b1;
                                end
                            end
                        end
                        default: begin
                            mode_next = MODE_IDLE;
                        end
                    endcase
                end

                // End of buffer always ends the search
                if (is_last) begin
                    done = 1'b1;
                end

                res_valid        = done || has;
                res.value_byte   = has ? text_byte : 8'd0;
                res.has_byte     = has;
                res.done_res     = done;
                res.found        = found;
                res.value_length = count_next;

                // Rearm on the last byte, otherwise hold until it arrives
                if (done) begin
                    if (is_last) begin
                        mode_next     = MODE_IDLE;
                        pos_next      = 5'd0;
                        count_next    = 8'd0;
                        finished_next = 1'b0;
                    end else begin
                        finished_next = 1'b1;
                    end
                end
            end
        end
    end

    // Hold scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            pos_reg      <= 5'd0;
            count_reg    <= 8'd0;
            finished_reg <= 1'b0;
        end else begin
            mode_reg     <= mode_next;
            pos_reg      <= pos_next;
            count_reg    <= count_next;
            finished_reg <= finished_next;
        end
    end

endmodule

FILE: rtl/jkse_out_skid.sv
// ----------------------------------------------------------------------------
// jkse_out_skid
// Result register with one skid entry, so input keeps flowing on a stall.
// ----------------------------------------------------------------------------
module jkse_out_skid
    import jkse_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    input  jkse_result_t in_res,
    output logic         skid_full,
    output logic         out_valid,
    input  logic         out_ready,
    output jkse_result_t out_res
);

    logic         main_valid_reg;
    jkse_result_t main_reg;
    logic         skid_valid_reg;
    jkse_result_t skid_reg;

    // Control: main register drains first, skid refills it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (main_valid_reg && !out_ready) begin
            if (in_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            main_valid_reg <= 1'b1;
            skid_valid_reg <= in_valid;
        end else begin
            main_valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (main_valid_reg && !out_ready) begin
            if (in_valid) begin
                skid_reg <= in_res;
            end
        end else if (skid_valid_reg) begin
            main_reg <= skid_reg;
            if (in_valid) begin
                skid_reg <= in_res;
            end
        end else if (in_valid) begin
            main_reg <= in_res;
        end
    end

    assign skid_full = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

endmodule

FILE: rtl/json_key_string_extractor_top.sv
// ----------------------------------------------------------------------------
// json_key_string_extractor_top
// Extracts the string value of a configured key from a streamed JSON text.
// ----------------------------------------------------------------------------
// Usage:
//   Text bytes enter on the s_ channel, one per item, s_tlast on the final
//   byte of a buffer. Program the key, its length and the value capacity on
//   the cfg_ port while the block is idle. Each value byte leaves on the m_
//   channel with m_tuser set; the item that ends the search has m_tlast set
//   and reports found in m_tdata[8]. Bytes that produce no result leave
//   nothing on m_.
// Throughput: one text byte per cycle while s_tready is high, set by the
//   scan state machine with its key character mux.
// Output: each result is registered in the result register or skid entry.
// Stall: a result register plus one skid entry part the two sides;
//   s_tready drops only while the skid entry is occupied.
// Reset: aresetn (synchronous, active low) clears the scan, empties the
//   output, sets the key to empty and the capacity to its maximum.
//   After a search ends, bytes are dropped until s_tlast rearms the block.
// ----------------------------------------------------------------------------
module json_key_string_extractor_top
    import jkse_pkg::*;
#(
    parameter int MAX_KEY_CHARS      = 16,
    parameter int MAX_VALUE_CAPACITY = 256
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // text_byte
    input  logic                   s_tlast,   // is_last
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,   // value_byte, found, value_length
    output logic                   m_tuser,   // has_byte
    output logic                   m_tlast    // done_res
);

    localparam int KLEN_W = $clog2(MAX_KEY_CHARS + 1);
    localparam int CAP_W  = $clog2(MAX_VALUE_CAPACITY + 1);

    logic [7:0]        key_bytes [MAX_KEY_CHARS];
    logic [KLEN_W-1:0] key_len;
    logic [CAP_W-1:0]  capacity;
    logic              in_accept;
    logic              res_valid;
    jkse_result_t      res;
    logic              skid_full;
    jkse_result_t      out_res;

    assign s_tready  = !skid_full;
    assign in_accept = s_tvalid && s_tready;

    jkse_cfg_regs #(
        .MAX_KEY_CHARS      (MAX_KEY_CHARS),
        .MAX_VALUE_CAPACITY (MAX_VALUE_CAPACITY)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .key_bytes (key_bytes),
        .key_len   (key_len),
        .capacity  (capacity)
    );

    jkse_scan #(
        .MAX_KEY_CHARS      (MAX_KEY_CHARS),
        .MAX_VALUE_CAPACITY (MAX_VALUE_CAPACITY)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .text_byte (s_tdata),
        .is_last   (s_tlast),
        .key_bytes (key_bytes),
        .key_len   (key_len),
        .capacity  (capacity),
        .res_valid (res_valid),
        .res       (res)
    );

    jkse_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_res    (res),
        .skid_full (skid_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the result fields onto the stream
    assign m_tdata = {7'd0, out_res.value_length, out_res.found, out_res.value_byte};
    assign m_tuser = out_res.has_byte;
    assign m_tlast = out_res.done_res;

endmodule

FILE: rtl/jkse_checker.sv
// ----------------------------------------------------------------------------
// jkse_checker
// Port-level checks for the extractor, bound to the top level.
// ----------------------------------------------------------------------------
module jkse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // Hold a stalled result item
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result item changed");

    // An item that does not end the search carries a value byte
    a_nodone_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser)
        else $error("empty result item without done");

    // Found appears only on the item that ends the search
    a_found_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tlast)
        else $error("found without done");

    // No value byte means a zero data byte
    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
        else $error("value byte set without has_byte");

    // An emitted byte counts itself
    a_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[16:9] != 8'd0)
        else $error("value byte with zero length");

endmodule

bind json_key_string_extractor_top jkse_checker u_jkse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
